// ===== rtl/bpskrot_pkg.sv =====
// bpskrot_pkg: shared types, register codes and the quarter-wave sine table function
// for the bpsk modulator with rotator; depends on nothing
`default_nettype none

package bpskrot_pkg;

  typedef struct packed {
    logic command;
    logic data_bit;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] i_sample;
    logic signed [15:0] q_sample;
    logic               last;
  } out_rsp_t;

  typedef enum logic [1:0] {
    REG_AMPLITUDE   = 2'd0,
    REG_PHASE_STEP  = 2'd1,
    REG_SAMPLES_SYM = 2'd2,
    REG_TONE_PERIOD = 2'd3
  } reg_idx_e;

  localparam logic CMD_PREAMBLE = 1'b0;
  localparam logic CMD_DATA     = 1'b1;

  localparam logic [14:0] AMPLITUDE_RST   = 15'd3000;
  localparam logic [31:0] PHASE_STEP_RST  = 32'd68356;
  localparam logic [4:0]  SAMPLES_SYM_RST = 5'd10;
  localparam logic [10:0] TONE_PERIOD_RST = 11'd100;

  localparam logic signed [16:0] SYM_POS = 17'sd32768;
  localparam logic signed [16:0] SYM_NEG = -17'sd32768;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  // controller to datapath
  typedef struct packed {
    logic sym_load;
    logic sym_bit;
    logic div_start;
    logic tone_rd;
    logic tone_cap;
    logic issue;
    logic issue_last;
    logic tone_adv;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       adv;
    logic       div_busy;
    logic       s1_empty;
    logic [4:0] sps;
  } stat_t;

  // q15 sine of m / 2^bits turn, first quarter, integer series; elaboration only
  function automatic logic [14:0] quarter_sine(input int m, input int bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    x    = (longint'(m) * TWO_PI_Q30) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > 32767) begin
      v = 32767;
    end
    return v[14:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bpskrot_div.sv =====
// bpskrot_div: bit-serial restoring divider for the preamble tone phase,
// one quotient bit per cycle; depends on bpskrot_pkg
`default_nettype none

module bpskrot_div
  import bpskrot_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [9:0]                 tone_index_i,
  input  wire logic [10:0]                period_i,
  output logic                            busy_o,
  output logic [SINE_TABLE_BITS-1:0]      quot_o
);

  localparam int B  = SINE_TABLE_BITS;
  localparam int N  = 10 + B;
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  dvd_q;
  logic [10:0]   rem_q;
  logic [B-1:0]  quot_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;

  logic [11:0]   r2;
  logic          ge;
  logic [11:0]   r2_sub;

  assign r2     = {rem_q, dvd_q[N-1]};
  assign ge     = r2 >= {1'b0, period_i};
  assign r2_sub = r2 - {1'b0, period_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(N);
    end else if (busy_q) begin
      busy_q <= cnt_q != CW'(1);
      cnt_q  <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= {tone_index_i, {B{1'b0}}};
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[N-2:0], 1'b0};
      rem_q  <= ge ? r2_sub[10:0] : r2[10:0];
      quot_q <= {quot_q[B-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== rtl/bpskrot_dp.sv =====
// bpskrot_dp: config registers, phase and tone state, sine rom, rotate and scale pipeline
// and output register; depends on bpskrot_pkg and bpskrot_div
`default_nettype none

module bpskrot_dp
  import bpskrot_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire cmd_t         cmd_i,
  output stat_t             stat_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output out_rsp_t          out_rsp_o
);

  localparam int B       = SINE_TABLE_BITS;
  localparam int AW      = B - 1;
  localparam int QUARTER = 1 << (B - 2);

  // config registers
  logic [14:0] amp_q;
  logic [31:0] step_q;
  logic [4:0]  sps_q;
  logic [10:0] tper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q  <= AMPLITUDE_RST;
      step_q <= PHASE_STEP_RST;
      sps_q  <= SAMPLES_SYM_RST;
      tper_q <= TONE_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_AMPLITUDE:   amp_q  <= cfg_data_i[14:0];
        REG_PHASE_STEP:  step_q <= cfg_data_i;
        REG_SAMPLES_SYM: sps_q  <= cfg_data_i[4:0];
        REG_TONE_PERIOD: tper_q <= cfg_data_i[10:0];
      endcase
    end
  end

  logic [10:0] period_eff;
  assign period_eff = (tper_q == 11'd0) ? 11'd1 : tper_q;

  // pipeline moves as a whole when the output register is free
  logic adv;
  logic take;
  assign adv  = !out_valid_o || !out_stall_i;
  assign take = cmd_i.issue && adv;

  // phase and tone state
  logic [31:0] phase_q;
  logic [9:0]  tone_q;
  logic [10:0] tone_next;

  assign tone_next = {1'b0, tone_q} + 11'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      tone_q  <= '0;
    end else if (take) begin
      phase_q <= phase_q + step_q;
      if (cmd_i.tone_adv) begin
        tone_q <= (tone_next >= period_eff || tone_next[10]) ? 10'd0 : tone_next[9:0];
      end
    end
  end

  // tone phase divider
  logic         div_busy;
  logic [B-1:0] div_quot;

  bpskrot_div #(
    .SINE_TABLE_BITS(B)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .tone_index_i(tone_q),
    .period_i    (period_eff),
    .busy_o      (div_busy),
    .quot_o      (div_quot)
  );

  // quarter-wave sine rom
  logic [14:0] rom [QUARTER+1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    assign rom[g] = quarter_sine(g, B);
  end

  // {negate, rom address} for a full-turn table index
  function automatic logic [B-1:0] rom_map(input logic [B-1:0] idx);
    logic [AW-1:0] k;
    k = {1'b0, idx[B-3:0]};
    rom_map = idx[B-2] ? {idx[B-1], AW'(QUARTER) - k} : {idx[B-1], k};
  endfunction

  logic [B-1:0] idx_s;
  logic [B-1:0] idx_c;
  logic [B-1:0] idx_t;
  logic [B-1:0] map_s;
  logic [B-1:0] map_c;
  logic         rom_en;

  assign idx_s  = phase_q[31 -: B];
  assign idx_c  = idx_s + B'(QUARTER);
  assign idx_t  = div_quot + B'(QUARTER);
  assign map_s  = rom_map(idx_s);
  assign map_c  = rom_map(cmd_i.tone_rd ? idx_t : idx_c);
  assign rom_en = cmd_i.tone_rd || adv;

  logic [14:0] rom_c_q;
  logic [14:0] rom_s_q;
  logic        neg_c_q;
  logic        neg_s_q;

  always_ff @(posedge clk_i) begin
    if (rom_en) begin
      rom_c_q <= rom[map_c[AW-1:0]];
      rom_s_q <= rom[map_s[AW-1:0]];
      neg_c_q <= map_c[B-1];
      neg_s_q <= map_s[B-1];
    end
  end

  logic signed [15:0] cos_v;
  logic signed [15:0] sin_v;

  assign cos_v = neg_c_q ? -$signed({1'b0, rom_c_q}) : $signed({1'b0, rom_c_q});
  assign sin_v = neg_s_q ? -$signed({1'b0, rom_s_q}) : $signed({1'b0, rom_s_q});

  // symbol value
  logic signed [16:0] sym_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sym_load) begin
      sym_q <= cmd_i.sym_bit ? SYM_NEG : SYM_POS;
    end else if (cmd_i.tone_cap) begin
      sym_q <= 17'(cos_v);
    end
  end

  // stage 1: rom data and symbol
  logic               s1_valid_q;
  logic               s1_last_q;
  logic signed [16:0] s1_sym_q;
  // stage 2: symbol times carrier
  logic               s2_valid_q;
  logic               s2_last_q;
  logic signed [31:0] s2_i_q;
  logic signed [31:0] s2_q_q;
  // stage 3: times amplitude
  logic               s3_valid_q;
  logic               s3_last_q;
  logic signed [47:0] s3_i_q;
  logic signed [47:0] s3_q_q;
  // output register
  logic               out_valid_q;
  out_rsp_t           out_q;

  logic signed [32:0] p1_i;
  logic signed [32:0] p1_q;
  logic signed [15:0] amp_s;
  logic signed [47:0] p2_i;
  logic signed [47:0] p2_q;
  logic signed [47:0] rnd_i;
  logic signed [47:0] rnd_q;
  logic signed [47:0] sh_i;
  logic signed [47:0] sh_q;

  assign p1_i  = s1_sym_q * cos_v;
  assign p1_q  = s1_sym_q * sin_v;
  assign amp_s = $signed({1'b0, amp_q});
  assign p2_i  = s2_i_q * amp_s;
  assign p2_q  = s2_q_q * amp_s;
  // truncate toward zero
  assign rnd_i = s3_i_q + (s3_i_q[47] ? 48'sh3FFF_FFFF : 48'sd0);
  assign rnd_q = s3_q_q + (s3_q_q[47] ? 48'sh3FFF_FFFF : 48'sd0);
  assign sh_i  = rnd_i >>> 30;
  assign sh_q  = rnd_q >>> 30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= cmd_i.issue;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_last_q      <= cmd_i.issue_last;
      s1_sym_q       <= sym_q;
      s2_last_q      <= s1_last_q;
      s2_i_q         <= p1_i[31:0];
      s2_q_q         <= p1_q[31:0];
      s3_last_q      <= s2_last_q;
      s3_i_q         <= p2_i;
      s3_q_q         <= p2_q;
      out_q.i_sample <= sh_i[15:0];
      out_q.q_sample <= sh_q[15:0];
      out_q.last     <= s3_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_rsp_o       = out_q;
  assign stat_o.adv      = adv;
  assign stat_o.div_busy = div_busy;
  assign stat_o.s1_empty = !s1_valid_q;
  assign stat_o.sps      = sps_q;

endmodule

`default_nettype wire

// ===== rtl/bpskrot_ctrl.sv =====
// bpskrot_ctrl: request sequencer; accepts requests and issues samples into the datapath
// depends on bpskrot_pkg
`default_nettype none

module bpskrot_ctrl
  import bpskrot_pkg::*;
#(
  parameter int MAX_SAMPLES_PER_SYMBOL = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire in_req_t in_req_i,
  output cmd_t         cmd_o,
  input  wire stat_t   stat_i
);

  localparam int         MAX   = MAX_SAMPLES_PER_SYMBOL;
  localparam int         CW    = (MAX > 1) ? $clog2(MAX) : 1;
  localparam logic [6:0] MAX_N = 7'(MAX);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_TWAIT = 5'b00100,
    S_TCAP  = 5'b01000,
    S_ISSUE = 5'b10000
  } state_e;

  state_e        state_q;
  state_e        state_d;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] rem_d;
  logic          pre_q;
  logic          pre_d;

  logic [6:0]    sps_ext;
  logic [6:0]    n_full;
  logic [6:0]    n_m1;

  assign sps_ext = {2'b00, stat_i.sps};
  assign n_full  = (sps_ext == 7'd0) ? 7'd1 : ((sps_ext > MAX_N) ? MAX_N : sps_ext);
  assign n_m1    = n_full - 7'd1;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    pre_d   = pre_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.command == CMD_DATA) begin
            cmd_o.sym_load = 1'b1;
            cmd_o.sym_bit  = in_req_i.data_bit;
            rem_d          = n_m1[CW-1:0];
            pre_d          = 1'b0;
            state_d        = S_ISSUE;
          end else begin
            cmd_o.div_start = 1'b1;
            rem_d           = '0;
            pre_d           = 1'b1;
            state_d         = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = S_TWAIT;
        end
      end
      S_TWAIT: begin
        if (stat_i.s1_empty) begin
          cmd_o.tone_rd = 1'b1;
          state_d       = S_TCAP;
        end
      end
      S_TCAP: begin
        cmd_o.tone_cap = 1'b1;
        state_d        = S_ISSUE;
      end
      S_ISSUE: begin
        cmd_o.issue      = 1'b1;
        cmd_o.issue_last = rem_q == '0;
        cmd_o.tone_adv   = pre_q;
        if (stat_i.adv) begin
          if (rem_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rem_d = rem_q - CW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q   <= '0;
      pre_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      pre_q   <= pre_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bpsk_modulator_with_rotator_top.sv =====
// bpsk_modulator_with_rotator_top: bpsk modulator with carrier rotator, top level
// depends on bpskrot_pkg, bpskrot_ctrl, bpskrot_dp
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   in_req_i  (command, data_bit)
//   out       output     out_valid_o / out_stall_i out_rsp_o (i_sample, q_sample, last)
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// a data bit issues n samples, n being samples_per_symbol clamped to 1..MAX_SAMPLES_PER_SYMBOL,
// one sample issued per cycle unless the output stalls; samples then pass the registered rotate and scale pipeline
// a preamble request waits on the bit-serial
// divider that finds the tone phase (one quotient bit per cycle)
// reset loads the register defaults and zeroes phase and tone index; no clearing pass
// an output stall freezes the whole sample pipeline; new requests wait until the controller is idle again
`default_nettype none

module bpsk_modulator_with_rotator_top
  import bpskrot_pkg::*;
#(
  parameter int MAX_SAMPLES_PER_SYMBOL = 16,
  parameter int SINE_TABLE_BITS        = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_req_t     in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_rsp_t         out_rsp_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  bpskrot_ctrl #(
    .MAX_SAMPLES_PER_SYMBOL(MAX_SAMPLES_PER_SYMBOL)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i  (in_req_i),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  bpskrot_dp #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // divider runs once started
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> stat.div_busy)
    else $error("divider not busy after start");

  // tone lookup only when the rom registers carry no sample
  a_tone_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.tone_rd |-> stat.s1_empty)
    else $error("tone lookup overwrote a sample in flight");

  // a blocked issue is held
  a_issue_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.issue && !stat.adv) |=> (cmd.issue && $stable(cmd.issue_last)))
    else $error("blocked sample issue dropped");

  // no request is taken while samples are still being issued
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> in_stall_o)
    else $error("request accepted during issue");

endmodule

`default_nettype wire
